// ----- rtl/core/bpid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Balance PID package
// Shared types, widths and register codes for the balance PID controller.
// ----------------------------------------------------------------------------
package bpid_pkg;

  localparam int ERR_W   = 16;  // pitch error and stored state width
  localparam int GAIN_W  = 16;  // unsigned Q8.8 gain width
  localparam int LIM_W   = 15;  // limit register width
  localparam int DRIVE_W = 16;  // drive output width
  localparam int IDX_W   = 3;   // configuration index width
  localparam int DATA_W  = 16;  // configuration data width
  localparam int PROD_W  = 34;  // 17-bit signed by 17-bit signed product
  localparam int ACC_W   = 36;  // sum of three products with headroom
  localparam int SCALE_SH = 15; // drive = acc / 2^15

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_TILT_LIMIT     = 3'd4;

  // Reset values of the registers
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = 16'd2778;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST     = 16'd256;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST     = 16'd19712;
  localparam logic [LIM_W-1:0]  INTEGRAL_LIMIT_RST = 15'd23040;
  localparam logic [LIM_W-1:0]  TILT_LIMIT_RST     = 15'd6400;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7FFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 16'sh8000;

  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } gains_t;

  // Terms of one sample after the integral and difference update
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W:0]   diff;
    logic signed [ERR_W-1:0] sum;
    logic                    cut;
  } terms_t;

endpackage

// ----- rtl/core/bpid_pitch_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch sample channel
// Valid/ready channel that carries one signed pitch error sample.
// ----------------------------------------------------------------------------
interface bpid_pitch_if;
  logic                             valid;
  logic                             ready;
  logic signed [bpid_pkg::ERR_W-1:0] pitch_error;

  modport source (output valid, output pitch_error, input ready);
  modport sink   (input valid, input pitch_error, output ready);
endinterface

// ----- rtl/core/bpid_drive_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive result channel
// Valid/ready channel that carries the motor drive and the cutoff flag.
// ----------------------------------------------------------------------------
interface bpid_drive_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpid_pkg::DRIVE_W-1:0] drive;
  logic                               cut_off;

  modport source (output valid, output drive, output cut_off, input ready);
  modport sink   (input valid, input drive, input cut_off, output ready);
endinterface

// ----- rtl/core/bpid_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface bpid_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpid_pkg::IDX_W-1:0]    index;
  logic [bpid_pkg::DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/bpid_drive.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Balance PID drive datapath
// Single registered pass: gain products, sum, scale, saturate and output.
// ----------------------------------------------------------------------------
module bpid_drive (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bpid_pkg::terms_t     terms,
  input  bpid_pkg::gains_t     gains,
  bpid_drive_if.source         result
);

  // Gain products
  logic signed [bpid_pkg::PROD_W-1:0]   p_prop;
  logic signed [bpid_pkg::PROD_W-1:0]   p_integ;
  logic signed [bpid_pkg::PROD_W-1:0]   p_deriv;

  // Output stage
  logic                                 out_valid;
  logic signed [bpid_pkg::DRIVE_W-1:0]  out_drive;
  logic                                 out_cut;

  logic                                 out_load;

  logic signed [bpid_pkg::ACC_W-1:0]    acc;
  logic signed [bpid_pkg::ACC_W-1:0]    acc_biased;
  logic signed [bpid_pkg::ACC_W-bpid_pkg::SCALE_SH-1:0] quot;
  logic signed [bpid_pkg::DRIVE_W-1:0]  drive_next;

  assign out_load = !out_valid || result.ready;
  assign in_ready = out_load;

  // Products, sum, truncate toward zero by biasing negatives, saturate; cut forces zero
  always_comb begin
    p_prop  = $signed({1'b0, gains.prop})
            * $signed({terms.err[bpid_pkg::ERR_W-1], terms.err});
    p_integ = $signed({1'b0, gains.integ})
            * $signed({terms.sum[bpid_pkg::ERR_W-1], terms.sum});
    p_deriv = $signed({1'b0, gains.deriv}) * terms.diff;
    acc = {{2{p_prop[bpid_pkg::PROD_W-1]}}, p_prop}
        + {{2{p_integ[bpid_pkg::PROD_W-1]}}, p_integ}
        + {{2{p_deriv[bpid_pkg::PROD_W-1]}}, p_deriv};
    acc_biased = acc;
    if (acc[bpid_pkg::ACC_W-1]) begin
      acc_biased = acc + bpid_pkg::ACC_W'((1 << bpid_pkg::SCALE_SH) - 1);
    end
    quot = acc_biased[bpid_pkg::ACC_W-1:bpid_pkg::SCALE_SH];
    if (quot > (bpid_pkg::ACC_W-bpid_pkg::SCALE_SH)'(bpid_pkg::DRIVE_MAX)) begin
      drive_next = bpid_pkg::DRIVE_MAX;
    end else if (quot < (bpid_pkg::ACC_W-bpid_pkg::SCALE_SH)'(bpid_pkg::DRIVE_MIN)) begin
      drive_next = bpid_pkg::DRIVE_MIN;
    end else begin
      drive_next = quot[bpid_pkg::DRIVE_W-1:0];
    end
    if (terms.cut) begin
      drive_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_drive <= drive_next;
      out_cut   <= terms.cut;
    end
  end

  assign result.valid   = out_valid;
  assign result.drive   = out_drive;
  assign result.cut_off = out_cut;

endmodule

// ----- rtl/core/balance_pid_with_tilt_cutoff.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Balance PID with tilt cutoff
// PID controller with clamped integral and a drive cutoff beyond a tilt limit.
// ----------------------------------------------------------------------------
// One pitch error sample (signed, 1/128 degree) enters per clock while the
// output is not stalled, and one result leaves per sample, passing through
// the stage one register and then the result register. The input stage
// updates the clamped error sum and the last error right at acceptance, so a
// sample that follows in the next cycle already sees them. The second stage
// forms the three gain products (17x17 bits each), sums them, divides by
// 32768 truncating toward zero, saturates to 16 bits and forces the drive to
// zero with cut_off set when |pitch_error| >= tilt_limit, all in one pass
// into the result register. The error sum and last error update on every
// sample, cut off or not. Each stage stalls only when the stage behind it is
// full and stalled, so stage one can still take a sample while a finished
// result waits. Write the registers (prop_gain, integ_gain, deriv_gain,
// integral_limit, tilt_limit) only while the pipeline is empty; writes to
// indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
module balance_pid_with_tilt_cutoff (
  input  logic          clk,
  input  logic          rst,
  bpid_cfg_if.sink      cfg,
  bpid_pitch_if.sink    pitch,
  bpid_drive_if.source  result
);

  // Configuration registers
  bpid_pkg::gains_t                 gains;
  logic [bpid_pkg::LIM_W-1:0]       integral_limit;
  logic [bpid_pkg::LIM_W-1:0]       tilt_limit;

  // Controller state
  logic signed [bpid_pkg::ERR_W-1:0] error_sum;
  logic signed [bpid_pkg::ERR_W-1:0] prev_error;

  // Stage one register
  logic                              s1_valid;
  bpid_pkg::terms_t                  s1_terms;
  logic                              s1_ready;

  // Stage one logic
  logic signed [bpid_pkg::ERR_W:0]   err_ext;
  logic signed [bpid_pkg::ERR_W:0]   sum_raw;
  logic signed [bpid_pkg::ERR_W:0]   lim_pos;
  logic signed [bpid_pkg::ERR_W:0]   lim_neg;
  logic signed [bpid_pkg::ERR_W:0]   sum_next;
  logic        [bpid_pkg::ERR_W:0]   err_mag;
  bpid_pkg::terms_t                  terms_next;
  logic                              take;

  // The configuration port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop     <= bpid_pkg::PROP_GAIN_RST;
      gains.integ    <= bpid_pkg::INTEG_GAIN_RST;
      gains.deriv    <= bpid_pkg::DERIV_GAIN_RST;
      integral_limit <= bpid_pkg::INTEGRAL_LIMIT_RST;
      tilt_limit     <= bpid_pkg::TILT_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bpid_pkg::REG_PROP_GAIN:      gains.prop     <= cfg.data;
        bpid_pkg::REG_INTEG_GAIN:     gains.integ    <= cfg.data;
        bpid_pkg::REG_DERIV_GAIN:     gains.deriv    <= cfg.data;
        bpid_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg.data[bpid_pkg::LIM_W-1:0];
        bpid_pkg::REG_TILT_LIMIT:     tilt_limit     <= cfg.data[bpid_pkg::LIM_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Accept a sample whenever stage one is empty or moves on this cycle
  assign pitch.ready = !s1_valid || s1_ready;
  assign take        = pitch.valid && pitch.ready;

  always_comb begin
    err_ext  = {pitch.pitch_error[bpid_pkg::ERR_W-1], pitch.pitch_error};
    sum_raw  = {error_sum[bpid_pkg::ERR_W-1], error_sum} + err_ext;
    lim_pos  = {2'b00, integral_limit};
    lim_neg  = -lim_pos;
    // Clamp the running sum to plus or minus the integral limit
    if (sum_raw > lim_pos) begin
      sum_next = lim_pos;
    end else if (sum_raw < lim_neg) begin
      sum_next = lim_neg;
    end else begin
      sum_next = sum_raw;
    end
    // Magnitude fits 17 bits even for the most negative sample
    err_mag = err_ext[bpid_pkg::ERR_W] ? unsigned'(-err_ext) : unsigned'(err_ext);
    terms_next.err  = pitch.pitch_error;
    terms_next.diff = err_ext - {prev_error[bpid_pkg::ERR_W-1], prev_error};
    terms_next.sum  = sum_next[bpid_pkg::ERR_W-1:0];
    terms_next.cut  = err_mag >= {2'b00, tilt_limit};
  end

  // Advance the state on every transfer, cutoff or not
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      prev_error <= '0;
    end else if (take) begin
      error_sum  <= terms_next.sum;
      prev_error <= pitch.pitch_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pitch.ready) begin
      s1_valid <= pitch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_terms <= terms_next;
    end
  end

  // Products, scaling, saturation and the output register
  bpid_drive u_drive (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_ready (s1_ready),
    .terms    (s1_terms),
    .gains    (gains),
    .result   (result)
  );

  // A cut-off result always carries zero drive
  a_cut_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.cut_off |-> result.drive == '0)
    else $error("cut-off result with nonzero drive");

  // State is clear right after reset
  a_state_reset: assert property (@(posedge clk)
    $past(rst) |-> error_sum == '0 && prev_error == '0)
    else $error("controller state not cleared by reset");

  // The last error tracks the most recently accepted sample
  a_prev_track: assert property (@(posedge clk) disable iff (rst)
    take |=> prev_error == $past(pitch.pitch_error))
    else $error("last error does not follow accepted sample");

  // A stalled stage-one item stays put
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1_terms))
    else $error("stage one item lost while stalled");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Balance PID testbench
// Drives pitch samples and register writes into the controller, predicts each
// drive and cutoff flag in step with accepted samples, and checks every
// result transfer against the oldest prediction. A short table of corner
// cases runs first, followed by random phases under several gain and limit
// settings, with random idle gaps on the sample side and stalls on the
// result side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SETTLE_CYCLES   = 4;
  localparam int STALL_LIMIT     = 2000;  // cycles without any transfer
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 191;

  // Indexes past the register list; writes to them must be dropped
  localparam logic [bpid_pkg::IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
  localparam logic [bpid_pkg::IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic signed [bpid_pkg::DRIVE_W-1:0] drive;
    logic                                cut_off;
  } drive_res_t;

  // ROW_PINNED carries a hand-worked result, ROW_SAMPLE uses the predictor
  typedef enum logic [1:0] {ROW_SAMPLE, ROW_PINNED, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                           kind;
    logic [bpid_pkg::IDX_W-1:0]          idx;
    logic [bpid_pkg::DATA_W-1:0]         data;
    logic signed [bpid_pkg::ERR_W-1:0]   pitch;
    logic signed [bpid_pkg::DRIVE_W-1:0] drive;
    logic                                cut;
  } plan_row_t;

  localparam int PLAN_LEN = 41;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // straight out of reset: zero error, zero state, zero drive
    '{ROW_PINNED, '0, '0, 16'sd0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sd1, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, -16'sd1, '0, 1'b0},
    // exactly at the tilt limit, both signs
    '{ROW_PINNED, '0, '0, 16'sd6400, 16'sd0, 1'b1},
    '{ROW_PINNED, '0, '0, -16'sd6400, 16'sd0, 1'b1},
    // one below the tilt limit
    '{ROW_SAMPLE, '0, '0, 16'sd6399, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, -16'sd6399, '0, 1'b0},
    // full 16-bit extremes, beyond the stated pitch range
    '{ROW_PINNED, '0, '0, 16'sh7FFF, 16'sd0, 1'b1},
    '{ROW_PINNED, '0, '0, 16'sh8000, 16'sd0, 1'b1},
    '{ROW_PINNED, '0, '0, -16'sd23040, 16'sd0, 1'b1},
    '{ROW_SAMPLE, '0, '0, 16'sd3000, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sd3000, '0, 1'b0},
    // zero tilt limit: everything is cut off, zero pitch included
    '{ROW_WRITE, bpid_pkg::REG_TILT_LIMIT, 16'd0, '0, '0, 1'b0},
    '{ROW_PINNED, '0, '0, 16'sd0, 16'sd0, 1'b1},
    // oversized write keeps the low 15 bits (32767); zero integral limit
    '{ROW_WRITE, bpid_pkg::REG_TILT_LIMIT, 16'hFFFF, '0, '0, 1'b0},
    '{ROW_WRITE, bpid_pkg::REG_INTEGRAL_LIMIT, 16'd0, '0, '0, 1'b0},
    '{ROW_PINNED, '0, '0, 16'sh8000, 16'sd0, 1'b1},
    '{ROW_SAMPLE, '0, '0, 16'sd100, '0, 1'b0},
    // maximum gains: drive saturates both ways
    '{ROW_WRITE, bpid_pkg::REG_PROP_GAIN, 16'hFFFF, '0, '0, 1'b0},
    '{ROW_WRITE, bpid_pkg::REG_INTEG_GAIN, 16'hFFFF, '0, '0, 1'b0},
    '{ROW_WRITE, bpid_pkg::REG_DERIV_GAIN, 16'hFFFF, '0, '0, 1'b0},
    '{ROW_PINNED, '0, '0, 16'sd23040, 16'sh7FFF, 1'b0},
    '{ROW_PINNED, '0, '0, -16'sd23040, 16'sh8000, 1'b0},
    // widest integral clamp the register holds
    '{ROW_WRITE, bpid_pkg::REG_INTEGRAL_LIMIT, 16'hFFFF, '0, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, -16'sd20000, '0, 1'b0},
    // zero gains give zero drive; writes past the list must not disturb them
    '{ROW_WRITE, bpid_pkg::REG_PROP_GAIN, 16'd0, '0, '0, 1'b0},
    '{ROW_WRITE, bpid_pkg::REG_INTEG_GAIN, 16'd0, '0, '0, 1'b0},
    '{ROW_WRITE, bpid_pkg::REG_DERIV_GAIN, 16'd0, '0, '0, 1'b0},
    '{ROW_PINNED, '0, '0, 16'sd5000, 16'sd0, 1'b0},
    '{ROW_WRITE, IDX_UNUSED_LO, 16'hFFFF, '0, '0, 1'b0},
    '{ROW_WRITE, IDX_UNUSED_HI, 16'hFFFF, '0, '0, 1'b0},
    '{ROW_PINNED, '0, '0, -16'sd5000, 16'sd0, 1'b0},
    // back to the reset settings
    '{ROW_WRITE, bpid_pkg::REG_PROP_GAIN, bpid_pkg::PROP_GAIN_RST, '0, '0, 1'b0},
    '{ROW_WRITE, bpid_pkg::REG_INTEG_GAIN, bpid_pkg::INTEG_GAIN_RST, '0, '0, 1'b0},
    '{ROW_WRITE, bpid_pkg::REG_DERIV_GAIN, bpid_pkg::DERIV_GAIN_RST, '0, '0, 1'b0},
    '{ROW_WRITE, bpid_pkg::REG_INTEGRAL_LIMIT, {1'b0, bpid_pkg::INTEGRAL_LIMIT_RST},
      '0, '0, 1'b0},
    '{ROW_WRITE, bpid_pkg::REG_TILT_LIMIT, {1'b0, bpid_pkg::TILT_LIMIT_RST},
      '0, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sd1234, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, -16'sd777, '0, 1'b0}
  };

  logic clk;
  logic rst;

  bpid_cfg_if   cfg_ch ();
  bpid_pitch_if pitch_ch ();
  bpid_drive_if drive_ch ();

  balance_pid_with_tilt_cutoff DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .pitch  (pitch_ch),
    .result (drive_ch)
  );

  // Mirror of the controller: registers and the two state words
  int prop_q, integ_q, deriv_q, ilim_q, tilt_q;
  int err_sum_q, last_err_q;

  drive_res_t pending_drive [$];  // predicted results, oldest first
  int errors = 0;
  bit src_held = 1'b0;            // pitch valid currently driven high
  bit quiet = 1'b0;               // no sender gaps, no new receiver stalls
  int stall_left = 0;
  int walk = 0;                   // slowly drifting pitch, like a real tilt

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 100) $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Advance the controller mirror by one sample and return its result
  function automatic drive_res_t predict_drive(
      input logic signed [bpid_pkg::ERR_W-1:0] e);
    drive_res_t r;
    int ev, sum, mag;
    longint acc, q;
    ev = int'(e);
    sum = err_sum_q + ev;
    if (sum > ilim_q) sum = ilim_q;
    if (sum < -ilim_q) sum = -ilim_q;
    acc = longint'(prop_q) * ev + longint'(deriv_q) * (ev - last_err_q)
        + longint'(integ_q) * sum;
    q = acc / 32768;  // truncates toward zero
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    err_sum_q = sum;
    last_err_q = ev;
    mag = (ev < 0) ? -ev : ev;
    r.cut_off = (mag >= tilt_q);
    r.drive = r.cut_off ? '0 : bpid_pkg::DRIVE_W'(q);
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [bpid_pkg::DATA_W-1:0] rand_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return bpid_pkg::DATA_W'($urandom_range(0, 4096));
    return bpid_pkg::DATA_W'($urandom);
  endfunction

  function automatic logic [bpid_pkg::DATA_W-1:0] rand_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return bpid_pkg::DATA_W'(23040);
    return bpid_pkg::DATA_W'($urandom_range(0, 23040));
  endfunction

  function automatic logic signed [bpid_pkg::ERR_W-1:0] rand_pitch();
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      walk = walk + int'($urandom_range(0, 600)) - 300;
      if (walk > 23040) walk = 23040;
      if (walk < -23040) walk = -23040;
      v = walk;
    end else if (r < 55) begin
      v = int'($urandom_range(0, 3000)) - 1500;
    end else if (r < 70) begin
      // straddle the tilt limit
      v = tilt_q + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (r < 92) begin
      v = int'($urandom_range(0, 46080)) - 23040;
    end else begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return bpid_pkg::ERR_W'(v);
  endfunction

  // Hold the register write until accepted, then update the mirror.
  // The caller drops valid after the last write of a batch.
  task automatic write_reg(input logic [bpid_pkg::IDX_W-1:0] idx,
                           input logic [bpid_pkg::DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      bpid_pkg::REG_PROP_GAIN:      prop_q  = int'(val);
      bpid_pkg::REG_INTEG_GAIN:     integ_q = int'(val);
      bpid_pkg::REG_DERIV_GAIN:     deriv_q = int'(val);
      bpid_pkg::REG_INTEGRAL_LIMIT: ilim_q  = int'(val[bpid_pkg::LIM_W-1:0]);
      bpid_pkg::REG_TILT_LIMIT:     tilt_q  = int'(val[bpid_pkg::LIM_W-1:0]);
      default: ;
    endcase
  endtask

  // Offer one sample after a random gap; predict it on acceptance
  task automatic send_sample(input logic signed [bpid_pkg::ERR_W-1:0] e,
                             input bit pinned, input drive_res_t fixed_res);
    int gap;
    drive_res_t r;
    gap = quiet ? 0 : (($urandom_range(0, 1) == 0) ? 0 : idle_len());
    if (gap > 0) begin
      if (src_held) begin
        pitch_ch.valid <= 1'b0;
        src_held = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    pitch_ch.valid       <= 1'b1;
    pitch_ch.pitch_error <= e;
    src_held = 1'b1;
    do @(posedge clk); while (pitch_ch.ready !== 1'b1);
    r = predict_drive(e);
    pending_drive.push_back(pinned ? fixed_res : r);
  endtask

  // Stop offering samples until every predicted result has come back
  task automatic drain();
    if (src_held) begin
      pitch_ch.valid <= 1'b0;
      src_held = 1'b0;
    end
    while (pending_drive.size() != 0) @(posedge clk);
  endtask

  // Empty the pipeline and let it go quiet before touching registers
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [bpid_pkg::DATA_W-1:0] p,
                           input logic [bpid_pkg::DATA_W-1:0] i,
                           input logic [bpid_pkg::DATA_W-1:0] d,
                           input logic [bpid_pkg::DATA_W-1:0] il,
                           input logic [bpid_pkg::DATA_W-1:0] tl);
    settle();
    write_reg(bpid_pkg::REG_PROP_GAIN, p);
    write_reg(bpid_pkg::REG_INTEG_GAIN, i);
    write_reg(bpid_pkg::REG_DERIV_GAIN, d);
    write_reg(bpid_pkg::REG_INTEGRAL_LIMIT, il);
    write_reg(bpid_pkg::REG_TILT_LIMIT, tl);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls; none start while quiet
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      drive_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_len() - 1;
      drive_ch.ready <= 1'b0;
    end else begin
      drive_ch.ready <= 1'b1;
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    drive_res_t want;
    if (rst === 1'b0 && drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1) begin
      if (pending_drive.size() == 0) begin
        report_mismatch($sformatf("result with no sample pending: drive=%0d cut_off=%0b",
                                  drive_ch.drive, drive_ch.cut_off));
      end else begin
        want = pending_drive.pop_front();
        if (drive_ch.drive !== want.drive)
          report_mismatch($sformatf("drive got %0d, expected %0d",
                                    drive_ch.drive, want.drive));
        if (drive_ch.cut_off !== want.cut_off)
          report_mismatch($sformatf("cut_off got %0b, expected %0b",
                                    drive_ch.cut_off, want.cut_off));
      end
    end
  end

  // Watchdog: end the run when no channel has moved for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((pitch_ch.valid === 1'b1 && pitch_ch.ready === 1'b1) ||
          (drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    plan_row_t  row;
    drive_res_t fixed_res;
    // known values on every input from time zero
    rst = 1'b1;
    pitch_ch.valid = 1'b0;
    pitch_ch.pitch_error = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;

    prop_q     = int'(bpid_pkg::PROP_GAIN_RST);
    integ_q    = int'(bpid_pkg::INTEG_GAIN_RST);
    deriv_q    = int'(bpid_pkg::DERIV_GAIN_RST);
    ilim_q     = int'(bpid_pkg::INTEGRAL_LIMIT_RST);
    tilt_q     = int'(bpid_pkg::TILT_LIMIT_RST);
    err_sum_q  = 0;
    last_err_q = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner cases; register writes only with the pipeline empty
    for (int i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_WRITE) begin
        if (i == 0 || PLAN[i-1].kind != ROW_WRITE) settle();
        write_reg(row.idx, row.data);
        if (i == PLAN_LEN - 1 || PLAN[i+1].kind != ROW_WRITE) cfg_ch.valid <= 1'b0;
      end else begin
        fixed_res.drive   = row.drive;
        fixed_res.cut_off = row.cut;
        send_sample(row.pitch, row.kind == ROW_PINNED, fixed_res);
      end
    end

    // Random phases, each under its own register setting
    fixed_res = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(bpid_pkg::PROP_GAIN_RST, bpid_pkg::INTEG_GAIN_RST,
                     bpid_pkg::DERIV_GAIN_RST, {1'b0, bpid_pkg::INTEGRAL_LIMIT_RST},
                     {1'b0, bpid_pkg::TILT_LIMIT_RST});
        1: configure('1, '1, '1, '1, '1);
        2: configure('0, '0, '0, '0, bpid_pkg::DATA_W'(23040));
        3: configure(rand_gain(), rand_gain(), rand_gain(), rand_limit(), '0);
        default: configure(rand_gain(), rand_gain(), rand_gain(), rand_limit(),
                           rand_limit());
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 0) quiet <= ($urandom_range(0, 3) == 0);
        else if ($urandom_range(0, 29) == 0) quiet <= !quiet;
        // hold off now and then until every result is back
        if ((ph == 4 && n == ITEMS_PER_PHASE / 2) || $urandom_range(0, 199) == 0) drain();
        send_sample(rand_pitch(), 1'b0, fixed_res);
      end
    end

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
